@@ hdl/c8x_pkg.sv @@
// c8x_pkg: shared constants and types for the CHIP-8 instruction executor.
// No dependencies.
`timescale 1ns / 1ps
package c8x_pkg;
  localparam int MEM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [11:0] ADDR_MASK = 12'hfff;
  localparam logic [11:0] NNN_CLS = 12'h0E0;
  localparam logic [11:0] NNN_RET = 12'h0EE;
  localparam logic [7:0] NN_SKP  = 8'h9E;
  localparam logic [7:0] NN_SKNP = 8'hA1;
  localparam logic [7:0] NN_GDLY = 8'h07;
  localparam logic [7:0] NN_KEY  = 8'h0A;
  localparam logic [7:0] NN_SDLY = 8'h15;
  localparam logic [7:0] NN_SSND = 8'h18;
  localparam logic [7:0] NN_ADDI = 8'h1E;
  localparam logic [7:0] NN_FONT = 8'h29;
  localparam logic [7:0] NN_BCD  = 8'h33;
  localparam logic [7:0] NN_STOR = 8'h55;
  localparam logic [7:0] NN_LOAD = 8'h65;
  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_CLS  = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;
  typedef logic [1:0] kind_t;
endpackage

@@ hdl/chip8_instruction_executor.sv @@
// chip8_instruction_executor: CHIP-8 core; RAM and stack in synchronous memories.
// Depends on c8x_pkg.
//
// Input channel (in_valid/in_ready) takes one request: a load byte
// (in_operation=1) or one opcode to execute. Output channel
// (out_valid/out_ready) gives the results: one kind-0 or clear-screen result,
// or one sprite-row result per row for DXYN, out_last on the final one.
// A return does one stack read, DXYN a RAM read and a result per row, and
// FX65 a RAM read per register.
// One request is in flight at a time; in_ready is high only when idle.
// A result waits in the output register while the receiver stalls; the
// sequencer holds until it is taken.
// Reset clears registers, PC, I, stack pointer and timers; RAM and stack
// contents are undefined until written. No clearing pass.
`timescale 1ns / 1ps
module chip8_instruction_executor #(
  parameter int MEM_BYTES   = c8x_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_instruction,
  input  logic [15:0] in_key_mask,
  input  logic [3:0]  in_pressed_key,
  input  logic [7:0]  in_random_byte,
  input  logic        in_draw_collision,
  input  logic [11:0] in_load_address,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_sprite_row,
  output logic [7:0]  out_sprite_x,
  output logic [7:0]  out_sprite_y,
  output logic [3:0]  out_row_index,
  output logic        out_last,
  output logic [11:0] out_next_pc
);
  localparam int AW = (MEM_BYTES >= 4096) ? 12 : $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_LOOP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_RET  = 3'd6;

  logic [2:0]  state_r;
  logic [7:0]  vregs_r [16];
  logic [11:0] pc_r, idx_r;
  logic [SW-1:0] sp_r;
  logic [7:0]  dly_r, snd_r;
  logic [15:0] op_r, keys_r;
  logic [3:0]  key_r;
  logic [7:0]  rnd_r;
  logic        col_r;
  logic [3:0]  cnt_r;
  logic [7:0]  bcd_r;
  logic [7:0]  sx_r, sy_r;

  logic [7:0]  ram [MEM_BYTES];
  logic [11:0] stk [STACK_DEPTH];
  logic [7:0]  ram_q;
  logic [11:0] stk_q;
  logic        ram_we, stk_we;
  logic [11:0] ram_wa, ram_ra;
  logic [11:0] ram_wi, ram_ri;
  logic [7:0]  ram_wd;
  logic [SW-1:0] stk_ra;
  logic [SW-1:0] sp_inc, sp_dec;

  logic        ov_r;
  logic [1:0]  okind_r;
  logic [7:0]  orow_r, ox_r, oy_r;
  logic [3:0]  oidx_r;
  logic        olast_r;
  logic [11:0] opc_r;

  // 12-bit address reduced modulo MEM_BYTES (full reduction for MEM_BYTES >= 512)
  function automatic logic [11:0] mem_wrap(input logic [11:0] a);
    logic [19:0] r;
    r = {8'd0, a};
    for (int k = 2; k >= 0; k--) begin
      if (r >= 20'(MEM_BYTES << k)) r = r - 20'(MEM_BYTES << k);
    end
    return r[11:0];
  endfunction

  assign ram_wi = mem_wrap(ram_wa);
  assign ram_ri = mem_wrap(ram_ra);

  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_wi[AW-1:0]] <= ram_wd;
    ram_q <= ram[ram_ri[AW-1:0]];
    if (stk_we) stk[sp_r] <= pc_r;
    stk_q <= stk[stk_ra];
  end

  logic [3:0] ox, oy, on;
  logic [7:0] onn, vx, vy;
  logic [11:0] onnn;
  assign ox = op_r[11:8];
  assign oy = op_r[7:4];
  assign on = op_r[3:0];
  assign onn = op_r[7:0];
  assign onnn = op_r[11:0];
  assign vx = vregs_r[ox];
  assign vy = vregs_r[oy];

  assign in_ready = (state_r == S_IDLE);
  assign sp_inc = (sp_r == SW'(STACK_DEPTH - 1)) ? '0 : sp_r + SW'(1);
  assign sp_dec = (sp_r == '0) ? SW'(STACK_DEPTH - 1) : sp_r - SW'(1);
  assign stk_ra = sp_dec;
  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_sprite_row = orow_r;
  assign out_sprite_x = ox_r;
  assign out_sprite_y = oy_r;
  assign out_row_index = oidx_r;
  assign out_last = olast_r;
  assign out_next_pc = opc_r;

  logic [11:0] pc2;
  logic [8:0] sum9;
  logic [7:0] bcd_h, bcd_t, bcd_n, bcd_o;
  logic [3:0] kidx;
  assign pc2 = pc_r + 12'd2;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
  assign bcd_t = vx - bcd_h * 8'd100;
  assign kidx = vx[3:0];

  // BCD digit split of the remainder below 100, one stage
  always_comb begin
    bcd_n = 8'd0;
    for (int d = 9; d >= 1; d--) begin
      if (bcd_t >= 8'(d * 10) && bcd_n == 8'd0) bcd_n = 8'(d);
    end
    bcd_o = bcd_t - bcd_n * 8'd10;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = '0;
    ram_wd = '0;
    ram_ra = idx_r + {8'd0, cnt_r};
    stk_we = 1'b0;
    if (state_r == S_IDLE && in_valid && in_operation) begin
      ram_we = 1'b1;
      ram_wa = in_load_address;
      ram_wd = in_load_data;
    end else if (state_r == S_EXEC && op_r[15:12] == 4'h2) begin
      stk_we = 1'b1;
    end else if (state_r == S_LOOP && op_r[15:12] == 4'hF) begin
      if (onn == c8x_pkg::NN_STOR) begin
        ram_we = 1'b1;
        ram_wa = idx_r + {8'd0, cnt_r};
        ram_wd = vregs_r[cnt_r];
      end else if (onn == c8x_pkg::NN_BCD) begin
        ram_we = 1'b1;
        ram_wa = idx_r + {8'd0, cnt_r};
        ram_wd = (cnt_r == 4'd0) ? bcd_h : (cnt_r == 4'd1) ? bcd_r : bcd_o;
      end
    end
  end

  task automatic emit(input logic [1:0] k, input logic lst, input logic [11:0] npc);
    ov_r <= 1'b1;
    okind_r <= k;
    orow_r <= 8'd0;
    ox_r <= 8'd0;
    oy_r <= 8'd0;
    oidx_r <= 4'd0;
    olast_r <= lst;
    opc_r <= npc;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++) vregs_r[i] <= 8'd0;
      pc_r <= '0;
      idx_r <= '0;
      sp_r <= '0;
      dly_r <= '0;
      snd_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready && !(state_r == S_RDW && op_r[15:12] == 4'hD)) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_instruction;
            keys_r <= in_key_mask;
            key_r <= in_pressed_key;
            rnd_r <= in_random_byte;
            col_r <= in_draw_collision;
            cnt_r <= 4'd0;
            if (in_operation) begin
              emit(c8x_pkg::KIND_DONE, 1'b1, pc_r);
              state_r <= S_OUT;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          case (op_r[15:12])
            4'h0: begin
              if (onnn == c8x_pkg::NNN_CLS) begin
                pc_r <= pc2;
                emit(c8x_pkg::KIND_CLS, 1'b1, pc2);
              end else if (onnn == c8x_pkg::NNN_RET) begin
                sp_r <= sp_dec;
                state_r <= S_RET;
              end else begin
                pc_r <= pc2;
                emit(c8x_pkg::KIND_DONE, 1'b1, pc2);
              end
            end
            4'h1: begin
              pc_r <= onnn;
              emit(c8x_pkg::KIND_DONE, 1'b1, onnn);
            end
            4'h2: begin
              sp_r <= sp_inc;
              pc_r <= onnn;
              emit(c8x_pkg::KIND_DONE, 1'b1, onnn);
            end
            4'h3, 4'h4, 4'h5, 4'h9, 4'hE: begin
              logic sk;
              sk = 1'b0;
              case (op_r[15:12])
                4'h3: sk = (vx == onn);
                4'h4: sk = (vx != onn);
                4'h5: sk = (vx == vy);
                4'h9: sk = (vx != vy);
                default: begin
                  if (onn == c8x_pkg::NN_SKP) sk = keys_r[kidx];
                  else if (onn == c8x_pkg::NN_SKNP) sk = !keys_r[kidx];
                end
              endcase
              pc_r <= sk ? pc_r + 12'd4 : pc2;
              emit(c8x_pkg::KIND_DONE, 1'b1, sk ? pc_r + 12'd4 : pc2);
            end
            4'hB: begin
              pc_r <= onnn + {4'd0, vregs_r[0]};
              emit(c8x_pkg::KIND_DONE, 1'b1, onnn + {4'd0, vregs_r[0]});
            end
            4'hD: begin
              sx_r <= vx;
              sy_r <= vy;
              pc_r <= pc2;
              if (on == 4'd0) begin
                vregs_r[15] <= {7'd0, col_r};
                emit(c8x_pkg::KIND_DONE, 1'b1, pc2);
              end else begin
                state_r <= S_RD;
              end
            end
            4'hF: begin
              pc_r <= pc2;
              if (onn == c8x_pkg::NN_BCD || onn == c8x_pkg::NN_STOR) begin
                bcd_r <= bcd_n;
                state_r <= S_LOOP;
              end else if (onn == c8x_pkg::NN_LOAD) begin
                state_r <= S_RD;
              end else begin
                case (onn)
                  c8x_pkg::NN_GDLY: vregs_r[ox] <= dly_r;
                  c8x_pkg::NN_KEY:  vregs_r[ox] <= {4'd0, key_r};
                  c8x_pkg::NN_SDLY: dly_r <= vx;
                  c8x_pkg::NN_SSND: snd_r <= vx;
                  c8x_pkg::NN_ADDI: idx_r <= idx_r + {4'd0, vx};
                  c8x_pkg::NN_FONT: idx_r <= 12'({4'd0, vx} * 12'd5);
                  default: ;
                endcase
                emit(c8x_pkg::KIND_DONE, 1'b1, pc2);
              end
            end
            default: begin
              pc_r <= pc2;
              emit(c8x_pkg::KIND_DONE, 1'b1, pc2);
              case (op_r[15:12])
                4'h6: vregs_r[ox] <= onn;
                4'h7: vregs_r[ox] <= vx + onn;
                4'hA: idx_r <= onnn;
                4'hC: vregs_r[ox] <= onn & rnd_r;
                4'h8: begin
                  case (on)
                    4'h0: vregs_r[ox] <= vy;
                    4'h1: vregs_r[ox] <= vx | vy;
                    4'h2: vregs_r[ox] <= vx & vy;
                    4'h3: vregs_r[ox] <= vx ^ vy;
                    4'h4: begin
                      if (ox != 4'hF) vregs_r[ox] <= sum9[7:0];
                      vregs_r[15] <= {7'd0, sum9[8]};
                    end
                    4'h5: begin
                      if (ox == 4'hF) begin
                        vregs_r[15] <= (oy == 4'hF) ? 8'd0 : {7'd0, vx >= vy} - vy;
                      end else begin
                        vregs_r[15] <= {7'd0, vx >= vy};
                        vregs_r[ox] <= (oy == 4'hF) ? vx - {7'd0, vx >= vy} : vx - vy;
                      end
                    end
                    4'h6: begin
                      if (ox != 4'hF) vregs_r[ox] <= vx >> 1;
                      vregs_r[15] <= {7'd0, vx[0]};
                    end
                    4'h7: begin
                      if (ox == 4'hF) begin
                        vregs_r[15] <= (oy == 4'hF) ? 8'd0 : vy - {7'd0, vy >= vx};
                      end else begin
                        vregs_r[15] <= {7'd0, vy >= vx};
                        vregs_r[ox] <= (oy == 4'hF) ? {7'd0, vy >= vx} - vx : vy - vx;
                      end
                    end
                    4'hE: begin
                      if (ox != 4'hF) vregs_r[ox] <= vx << 1;
                      vregs_r[15] <= {7'd0, vx[7]};
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
          endcase
        end
        S_RET: begin
          pc_r <= stk_q + 12'd2;
          emit(c8x_pkg::KIND_DONE, 1'b1, stk_q + 12'd2);
          state_r <= S_OUT;
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          if (op_r[15:12] == 4'hD) begin
            if (!ov_r || out_ready) begin
              ov_r <= 1'b1;
              okind_r <= c8x_pkg::KIND_ROW;
              orow_r <= ram_q;
              ox_r <= sx_r;
              oy_r <= sy_r;
              oidx_r <= cnt_r;
              olast_r <= (cnt_r + 4'd1 == on);
              opc_r <= pc_r;
              if (cnt_r + 4'd1 == on) begin
                vregs_r[15] <= {7'd0, col_r};
                state_r <= S_OUT;
              end else begin
                cnt_r <= cnt_r + 4'd1;
                state_r <= S_RD;
              end
            end
          end else begin
            vregs_r[cnt_r] <= ram_q;
            if (cnt_r == ox) begin
              emit(c8x_pkg::KIND_DONE, 1'b1, pc_r);
              state_r <= S_OUT;
            end else begin
              cnt_r <= cnt_r + 4'd1;
              state_r <= S_RD;
            end
          end
        end
        S_LOOP: begin
          if ((onn == c8x_pkg::NN_BCD && cnt_r == 4'd2) ||
              (onn == c8x_pkg::NN_STOR && cnt_r == ox)) begin
            emit(c8x_pkg::KIND_DONE, 1'b1, pc_r);
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> ov_r) else $error("result missing while waiting");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ov_r) else $error("idle with pending result");
  a_row_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r != c8x_pkg::KIND_ROW) |-> olast_r)
    else $error("non-row result not last");
endmodule

@@ dv/chip8_instruction_executor_tb.sv @@
// Testbench for chip8_instruction_executor: a directed table, then random requests
// checked against an in-bench predictor of the CHIP-8 machine state.
// Depends on c8x_pkg and the executor RTL.
`timescale 1ns / 1ps
module chip8_instruction_executor_tb;

  typedef struct packed {
    c8x_pkg::kind_t kind;
    logic [7:0]  row;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  ri;
    logic        last;
    logic [11:0] pc;
  } chip_res_t;

  typedef struct {
    bit        op;
    bit [15:0] ins;
    bit [15:0] keys;
    bit [3:0]  key;
    bit [7:0]  rnd;
    bit        coll;
    bit [11:0] addr;
    bit [7:0]  data;
    bit        typed;
    c8x_pkg::kind_t tkind;
    bit [11:0] tpc;
  } chip_req_t;

  localparam bit OP_EXEC = 1'b0;
  localparam bit OP_LOAD = 1'b1;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic in_operation = 0, in_draw_collision = 0;
  logic [15:0] in_instruction = 0, in_key_mask = 0;
  logic [3:0] in_pressed_key = 0;
  logic [7:0] in_random_byte = 0, in_load_data = 0;
  logic [11:0] in_load_address = 0;
  logic out_valid, out_ready = 0, out_last;
  logic [1:0] out_kind;
  logic [7:0] out_sprite_row, out_sprite_x, out_sprite_y;
  logic [3:0] out_row_index;
  logic [11:0] out_next_pc;

  chip8_instruction_executor dut (.*);

  always #5 clk = ~clk;

  // machine state mirror
  bit [7:0]  vr [16];
  bit [11:0] pc_q, idx_q;
  bit [11:0] stk [16];
  bit [3:0]  sp_q;
  bit [7:0]  mem [4096];
  bit        mem_wr [4096];
  bit        stk_wr [16];
  bit [7:0]  dly_q, snd_q;

  chip_res_t pending_results[$];
  int errors = 0;
  bit hold_req = 0;
  int idle_cnt = 0;

  // directed opcodes after the load, clear, jump, call and return opening rows
  bit [15:0] ins_list [] = '{
    16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8017,
    16'h8016, 16'h801E, 16'h8018, 16'hC0F0, 16'hE09E,
    16'hE0A1, 16'hF00A, 16'hF015, 16'hF018, 16'hF007,
    16'hAFFE, 16'hF033, 16'hD012, 16'hD010, 16'hF029,
    16'hF11E, 16'hF155, 16'hF165, 16'h3000, 16'h4000,
    16'h5010, 16'h9010, 16'hB010, 16'hFFFF, 16'h0FFF
  };

  function automatic chip_res_t mk_res(c8x_pkg::kind_t k, bit [7:0] r, bit [7:0] x,
                                       bit [7:0] y, bit [3:0] ri, bit l);
    chip_res_t c;
    c.kind = k; c.row = r; c.x = x; c.y = y; c.ri = ri; c.last = l; c.pc = pc_q;
    return c;
  endfunction

  task automatic exec_opcode(chip_req_t s);
    bit [3:0] x, y, n;
    bit [7:0] nn, v, sx, sy;
    bit [11:0] nnn, nxt;
    bit [8:0] sum;
    bit f, clr;
    x = s.ins[11:8]; y = s.ins[7:4]; n = s.ins[3:0];
    nn = s.ins[7:0]; nnn = s.ins[11:0];
    nxt = pc_q + 12'd2;
    clr = 1'b0;
    if (s.op == OP_LOAD) begin
      mem[s.addr] = s.data;
      mem_wr[s.addr] = 1'b1;
      pending_results.push_back(mk_res(c8x_pkg::KIND_DONE, 8'd0, 8'd0, 8'd0, 4'd0, 1'b1));
      return;
    end
    case (s.ins[15:12])
      4'h0: begin
        if (nnn == c8x_pkg::NNN_CLS) clr = 1'b1;
        else if (nnn == c8x_pkg::NNN_RET) begin
          sp_q = sp_q - 4'd1;
          nxt = stk[sp_q] + 12'd2;
        end
      end
      4'h1: nxt = nnn;
      4'h2: begin
        stk[sp_q] = pc_q; stk_wr[sp_q] = 1'b1; sp_q = sp_q + 4'd1; nxt = nnn;
      end
      4'h3: if (vr[x] == nn) nxt += 12'd2;
      4'h4: if (vr[x] != nn) nxt += 12'd2;
      4'h5: if (vr[x] == vr[y]) nxt += 12'd2;
      4'h6: vr[x] = nn;
      4'h7: vr[x] = vr[x] + nn;
      4'h8: begin
        case (n)
          4'h0: vr[x] = vr[y];
          4'h1: vr[x] = vr[x] | vr[y];
          4'h2: vr[x] = vr[x] & vr[y];
          4'h3: vr[x] = vr[x] ^ vr[y];
          4'h4: begin
            sum = {1'b0, vr[x]} + {1'b0, vr[y]};
            vr[x] = sum[7:0]; vr[15] = {7'd0, sum[8]};
          end
          4'h5: begin vr[15] = {7'd0, vr[x] >= vr[y]}; vr[x] = vr[x] - vr[y]; end
          4'h6: begin f = vr[x][0]; vr[x] = vr[x] >> 1; vr[15] = {7'd0, f}; end
          4'h7: begin vr[15] = {7'd0, vr[y] >= vr[x]}; vr[x] = vr[y] - vr[x]; end
          4'hE: begin f = vr[x][7]; vr[x] = vr[x] << 1; vr[15] = {7'd0, f}; end
          default: ;
        endcase
      end
      4'h9: if (vr[x] != vr[y]) nxt += 12'd2;
      4'hA: idx_q = nnn;
      4'hB: nxt = nnn + {4'd0, vr[0]};
      4'hC: vr[x] = nn & s.rnd;
      4'hD: begin
        sx = vr[x]; sy = vr[y];
        pc_q = nxt;
        if (n == 0)
          pending_results.push_back(mk_res(c8x_pkg::KIND_DONE, 8'd0, 8'd0, 8'd0, 4'd0,
                                           1'b1));
        for (int r = 0; r < n; r++)
          pending_results.push_back(mk_res(c8x_pkg::KIND_ROW, mem[idx_q + 12'(r)], sx, sy,
                                           4'(r), r + 1 == n));
        vr[15] = {7'd0, s.coll};
        return;
      end
      4'hE: begin
        f = s.keys[vr[x][3:0]];
        if (nn == c8x_pkg::NN_SKP && f) nxt += 12'd2;
        else if (nn == c8x_pkg::NN_SKNP && !f) nxt += 12'd2;
      end
      default: begin
        v = vr[x];
        case (nn)
          c8x_pkg::NN_GDLY: vr[x] = dly_q;
          c8x_pkg::NN_KEY:  vr[x] = {4'd0, s.key};
          c8x_pkg::NN_SDLY: dly_q = v;
          c8x_pkg::NN_SSND: snd_q = v;
          c8x_pkg::NN_ADDI: idx_q = idx_q + {4'd0, v};
          c8x_pkg::NN_FONT: idx_q = 12'({4'd0, v} * 12'd5);
          c8x_pkg::NN_BCD: begin
            mem[idx_q] = v / 8'd100; mem[idx_q + 12'd1] = (v / 8'd10) % 8'd10;
            mem[idx_q + 12'd2] = v % 8'd10;
            mem_wr[idx_q] = 1'b1; mem_wr[idx_q + 12'd1] = 1'b1;
            mem_wr[idx_q + 12'd2] = 1'b1;
          end
          c8x_pkg::NN_STOR:
            for (int i = 0; i <= x; i++) begin
              mem[idx_q + 12'(i)] = vr[i]; mem_wr[idx_q + 12'(i)] = 1'b1;
            end
          c8x_pkg::NN_LOAD: for (int i = 0; i <= x; i++) vr[i] = mem[idx_q + 12'(i)];
          default: ;
        endcase
      end
    endcase
    pc_q = nxt;
    pending_results.push_back(mk_res(clr ? c8x_pkg::KIND_CLS : c8x_pkg::KIND_DONE, 8'd0,
                                     8'd0, 8'd0, 4'd0, 1'b1));
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(chip_req_t s);
    chip_res_t t;
    int g;
    in_valid <= 1;
    in_operation <= s.op; in_instruction <= s.ins; in_key_mask <= s.keys;
    in_pressed_key <= s.key; in_random_byte <= s.rnd; in_draw_collision <= s.coll;
    in_load_address <= s.addr; in_load_data <= s.data;
    do @(posedge clk); while (!in_ready);
    exec_opcode(s);
    if (s.typed) begin
      t = pending_results.pop_back();
      t.kind = s.tkind; t.pc = s.tpc;
      pending_results.push_back(t);
    end
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic chip_req_t rnd_req(bit op, bit [15:0] ins);
    chip_req_t s;
    s.op = op; s.ins = ins; s.keys = 16'($urandom); s.key = 4'($urandom);
    s.rnd = 8'($urandom); s.coll = 1'($urandom); s.addr = 12'($urandom);
    s.data = 8'($urandom);
    s.typed = 1'b0; s.tkind = c8x_pkg::KIND_DONE; s.tpc = 12'd0;
    return s;
  endfunction

  function automatic chip_req_t typed_req(bit op, bit [15:0] ins, c8x_pkg::kind_t k,
                                          bit [11:0] p);
    chip_req_t s;
    s = rnd_req(op, ins);
    s.typed = 1'b1; s.tkind = k; s.tpc = p;
    return s;
  endfunction

  // load any unwritten bytes a memory read is about to touch
  task automatic fill_span(bit [11:0] base, int cnt);
    chip_req_t s;
    for (int i = 0; i < cnt; i++)
      if (!mem_wr[base + 12'(i)]) begin
        s = rnd_req(OP_LOAD, 16'($urandom));
        s.addr = base + 12'(i);
        offer(s);
      end
  endtask

  function automatic bit [15:0] rnd_opcode();
    bit [15:0] ins;
    bit [7:0] fcodes [10] = '{c8x_pkg::NN_GDLY, c8x_pkg::NN_KEY, c8x_pkg::NN_SDLY,
                              c8x_pkg::NN_SSND, c8x_pkg::NN_ADDI, c8x_pkg::NN_FONT,
                              c8x_pkg::NN_BCD, c8x_pkg::NN_STOR, c8x_pkg::NN_LOAD, 8'h00};
    int p;
    ins = 16'($urandom);
    p = $urandom_range(0, 99);
    if (ins[15:12] == 4'hF && p < 80) ins[7:0] = fcodes[$urandom_range(0, 9)];
    if (ins[15:12] == 4'hE && p < 80) ins[7:0] = p[0] ? c8x_pkg::NN_SKP : c8x_pkg::NN_SKNP;
    if (ins[15:12] == 4'h0 && p < 70) ins[11:0] = p[0] ? c8x_pkg::NNN_CLS : c8x_pkg::NNN_RET;
    if (ins[15:12] == 4'hD && p < 60) ins[3:0] = 4'($urandom_range(0, 4));
    return ins;
  endfunction

  always @(posedge clk) begin
    chip_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_sprite_row, out_sprite_x, out_sprite_y, out_row_index,
              out_last, out_next_pc};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    chip_req_t dir_tab[$];
    chip_req_t s;
    bit [15:0] ins;
    int w;
    dir_tab.push_back(typed_req(OP_LOAD, 16'h0, c8x_pkg::KIND_DONE, 12'h000));
    dir_tab[0].addr = 12'hFFF;
    dir_tab.push_back(typed_req(OP_EXEC, 16'h00E0, c8x_pkg::KIND_CLS, 12'h002));
    dir_tab.push_back(typed_req(OP_EXEC, 16'h1FFE, c8x_pkg::KIND_DONE, 12'hFFE));
    dir_tab.push_back(typed_req(OP_EXEC, 16'h2100, c8x_pkg::KIND_DONE, 12'h100));
    dir_tab.push_back(typed_req(OP_EXEC, 16'h00EE, c8x_pkg::KIND_DONE, 12'h000));
    foreach (ins_list[i]) dir_tab.push_back(rnd_req(OP_EXEC, ins_list[i]));
    dir_tab[14].keys = 16'h0000;
    dir_tab[15].keys = 16'hFFFF;
    dir_tab[16].key = 4'hF;

    in_valid <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) offer(dir_tab[i]);

    for (int k = 0; k < 260; k++) begin
      if (k == 80) hold_req = 1;
      if (k == 160) begin
        in_valid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 15) begin
        offer(rnd_req(OP_LOAD, 16'($urandom)));
        continue;
      end
      ins = rnd_opcode();
      if (ins[15:12] == 4'h0 && ins[11:0] == c8x_pkg::NNN_RET && !stk_wr[sp_q - 4'd1])
        ins = {4'h2, ins[11:0]};
      if (ins[15:12] == 4'hD) fill_span(idx_q, int'(ins[3:0]));
      if (ins[15:12] == 4'hF && ins[7:0] == c8x_pkg::NN_LOAD)
        fill_span(idx_q, int'(ins[11:8]) + 1);
      offer(rnd_req(OP_EXEC, ins));
    end
    in_valid <= 0;

    w = 0;
    while (pending_results.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
hdl/c8x_pkg.sv
hdl/chip8_instruction_executor.sv
dv/chip8_instruction_executor_tb.sv
